[src/cfbq_pkg.sv]
// shared types, constants and helpers for the crossfaded biquad cascade
`default_nettype none
package cfbq_pkg;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_COEF   = 2'd1,
        FUNC_FADE   = 2'd2,
        FUNC_RSVD   = 2'd3
    } t_func;

    localparam int NUM_SECTIONS = 8;
    localparam int NUM_TAPS     = 5;
    localparam int MAX_CH       = 8;
    localparam int COEF_FRAC    = 29;
    localparam int DIV_BITS     = 50;

    localparam logic        CFG_CHANNELS  = 1'b0;
    localparam logic        CFG_FADE_LEN  = 1'b1;
    localparam logic [3:0]  CHANNELS_RST  = 4'd2;
    localparam logic [15:0] FADE_LEN_RST  = 16'd240;
    localparam logic signed [31:0] COEF_ONE = 32'sh2000_0000;

    function automatic logic signed [23:0] sat_sample(input logic signed [50:0] v);
        logic signed [23:0] r;
        if (v > 51'sd8388607) begin
            r = 24'sh7F_FFFF;
        end else if (v < -51'sd8388608) begin
            r = 24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/cfbq_div.sv]
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module cfbq_div
    import cfbq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DIV_BITS-1:0] i_dividend,
    input  wire logic [15:0]         i_divisor,
    output logic                     o_done,
    output logic [DIV_BITS-1:0]      o_quotient
);

    logic                r_busy;
    logic [5:0]          r_cnt;
    logic [15:0]         r_rem;
    logic [15:0]         r_dvs;
    logic [DIV_BITS-1:0] r_quo;
    logic [16:0]         w_trial;
    logic                w_fit;

    assign w_trial = {r_rem, r_quo[DIV_BITS-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_fit ? 16'(w_trial - {1'b0, r_dvs}) : w_trial[15:0];
                r_quo <= {r_quo[DIV_BITS-2:0], w_fit};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;

endmodule
`default_nettype wire

[src/crossfaded_biquad_cascade_unit.sv]
// crossfaded biquad cascade: two-bank df1 biquad chain with per-channel history
// usage:
//   slave stream takes requests: tuser is the kind (sample, coefficient write,
//   start fade), tdata carries channel, sample and coefficient address/value
//   master stream returns one result per accepted sample on a channel in use
//   config port writes channel count (index 0) and fade length (index 1)
// timing:
//   each section runs on one 32x32 multiplier fed by the coefficient memory,
//   and one chain has 8 sections; a sample without fade runs one chain
//   during a fade both banks run and the mix goes through a serial divider
//   coefficient and fade requests are applied when accepted
//   one item at a time; tready is high only while idle
// reset: identity coefficients, zero history, bank 0, no fade; no clearing pass
// stall: a finished result waits in the output register; the next request is
//   accepted meanwhile, and a new result waits until the register is taken
`default_nettype none
module crossfaded_biquad_cascade_unit
    import cfbq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,  // channel, sample_in, coef_bank, coef_section,
                                         // coef_index, coef_value, zero pad
    input  wire logic [1:0]  i_s_tuser,  // func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,  // channel_out, sample_out, zero pad
    output logic [1:0]       o_m_tuser,  // fading, bank_in_use
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_SEND, S_FMUL, S_FADD, S_FMAG, S_DIV, S_MIX, S_OUT
    } t_state;

    // memories
    logic [127:0]        r_hist_mem [128];
    logic [31:0]         r_coef_mem [80];
    logic [127:0]        r_hist_rd;
    logic [31:0]         r_coef_rd;
    logic [127:0]        r_hist_vld;
    logic [79:0]         r_coef_vld;
    logic                r_hvld;
    logic                r_cvld;

    t_state              r_state;
    logic [3:0]          r_chans;
    logic [15:0]         r_fade_len;
    logic                r_active;
    logic [15:0]         r_pos;
    logic                r_fade_run;

    logic [2:0]          r_ch;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_cur;
    logic signed [31:0]  r_a;
    logic signed [31:0]  r_t;
    logic                r_pass;
    logic [2:0]          r_sec;
    logic [2:0]          r_k;
    logic                r_bank_run;
    logic                r_fade_snap;
    logic                r_was_bank;
    logic signed [63:0]  r_prod;
    logic                r_psub;
    logic signed [63:0]  r_acc;
    logic signed [49:0]  r_mul;
    logic signed [49:0]  r_num;
    logic                r_neg;
    logic [49:0]         r_dividend;
    logic                r_div_start;
    logic signed [23:0]  r_res;

    logic                r_ovalid;
    logic [2:0]          r_och;
    logic signed [23:0]  r_osample;
    logic                r_ofading;
    logic                r_obank;

    // input fields
    t_func               w_func;
    logic [2:0]          w_in_ch;
    logic signed [23:0]  w_in_sample;
    logic                w_in_bank;
    logic [2:0]          w_in_sec;
    logic [2:0]          w_in_idx;
    logic [31:0]         w_in_coef;
    logic                w_accept;

    logic [3:0]          w_count;
    logic [15:0]         w_len;
    logic [16:0]         w_pos1;
    logic [15:0]         w_n;
    logic [6:0]          w_haddr;
    logic [6:0]          w_craddr;
    logic [6:0]          w_cwaddr;
    logic                w_cwe;
    logic [127:0]        w_hrow;
    logic signed [31:0]  w_coef;
    logic signed [31:0]  w_opnd;
    logic signed [63:0]  w_rnd;
    logic signed [63:0]  w_sh;
    logic signed [31:0]  w_y;
    logic signed [32:0]  w_diff;
    logic                w_div_done;
    logic [49:0]         w_quot;
    logic signed [50:0]  w_q;
    logic signed [50:0]  w_mix;
    logic                w_frame_end;

    assign w_func      = t_func'(i_s_tuser);
    assign w_in_ch     = i_s_tdata[2:0];
    assign w_in_sample = i_s_tdata[26:3];
    assign w_in_bank   = i_s_tdata[27];
    assign w_in_sec    = i_s_tdata[30:28];
    assign w_in_idx    = i_s_tdata[33:31];
    assign w_in_coef   = i_s_tdata[65:34];
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign w_count = (r_chans == 4'd0) ? 4'd1 :
                     (r_chans > 4'(MAX_CH)) ? 4'(MAX_CH) : r_chans;
    assign w_len   = (r_fade_len == 16'd0) ? 16'd1 : r_fade_len;
    assign w_pos1  = {1'b0, r_pos} + 17'd1;
    assign w_n     = (w_pos1 > {1'b0, w_len}) ? w_len : w_pos1[15:0];

    assign w_haddr  = {r_bank_run, r_sec, r_ch};
    assign w_craddr = 7'({r_bank_run, r_sec}) * 7'(NUM_TAPS) + 7'(r_k);
    assign w_cwaddr = 7'(w_in_bank) * 7'(NUM_TAPS * NUM_SECTIONS)
                    + 7'(w_in_sec) * 7'(NUM_TAPS) + 7'(w_in_idx);
    assign w_cwe    = w_accept && (w_func == FUNC_COEF) && (w_in_idx < 3'(NUM_TAPS));

    // unwritten entries read as identity section / zero history
    assign w_hrow = r_hvld ? r_hist_rd : '0;
    assign w_coef = r_cvld ? r_coef_rd : ((r_k == 3'd1) ? COEF_ONE : 32'sd0);

    // row: h0 x[n-1], h1 x[n-2], h2 y[n-1], h3 y[n-2]
    always_comb begin
        unique case (r_k)
            3'd1:    w_opnd = r_cur;
            3'd2:    w_opnd = w_hrow[31:0];
            3'd3:    w_opnd = w_hrow[63:32];
            3'd4:    w_opnd = w_hrow[95:64];
            default: w_opnd = w_hrow[127:96];
        endcase
    end

    assign w_rnd = r_acc + 64'sd268435456;
    assign w_sh  = w_rnd >>> COEF_FRAC;
    always_comb begin
        if (w_sh > 64'sd2147483647) begin
            w_y = 32'sh7FFF_FFFF;
        end else if (w_sh < -64'sd2147483648) begin
            w_y = 32'sh8000_0000;
        end else begin
            w_y = w_sh[31:0];
        end
    end

    assign w_diff = {r_t[31], r_t} - {r_a[31], r_a};
    assign w_q    = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
    assign w_mix  = {{19{r_a[31]}}, r_a} + w_q;
    assign w_frame_end = r_fade_run && ({1'b0, r_ch} == w_count - 4'd1);

    cfbq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // memories
    always_ff @(posedge i_clk) begin
        r_hist_rd <= r_hist_mem[w_haddr];
        if (r_state == S_SEND) begin
            r_hist_mem[w_haddr] <= {w_hrow[95:64], w_y, w_hrow[31:0], r_cur};
        end
        if (r_k < 3'(NUM_TAPS)) begin
            r_coef_rd <= r_coef_mem[w_craddr];
        end
        if (w_cwe && (w_cwaddr < 7'd80)) begin
            r_coef_mem[w_cwaddr] <= w_in_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chans     <= CHANNELS_RST;
            r_fade_len  <= FADE_LEN_RST;
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_fade_run  <= 1'b0;
            r_hist_vld  <= '0;
            r_coef_vld  <= '0;
            r_hvld      <= 1'b0;
            r_cvld      <= 1'b0;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
            r_k         <= '0;
        end else begin
            r_hvld      <= r_hist_vld[w_haddr];
            if (r_k < 3'(NUM_TAPS)) begin
                r_cvld <= r_coef_vld[w_craddr];
            end
            r_div_start <= 1'b0;
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_CHANNELS) begin
                    r_chans <= i_cfg_wdata[3:0];
                    if (i_cfg_wdata[3:0] != r_chans) begin
                        r_hist_vld <= '0;
                        r_fade_run <= 1'b0;
                        r_pos      <= '0;
                    end
                end else begin
                    r_fade_len <= i_cfg_wdata;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_func)
                            FUNC_SAMPLE: begin
                                if ({1'b0, w_in_ch} < w_count) begin
                                    r_ch        <= w_in_ch;
                                    r_x         <= 32'(w_in_sample);
                                    r_cur       <= 32'(w_in_sample);
                                    r_pass      <= 1'b0;
                                    r_sec       <= '0;
                                    r_k         <= '0;
                                    r_acc       <= '0;
                                    r_bank_run  <= r_active;
                                    r_fade_snap <= r_fade_run;
                                    r_was_bank  <= r_active;
                                    r_state     <= S_MAC;
                                end
                            end
                            FUNC_COEF: begin
                                if (w_cwe && (w_cwaddr < 7'd80)) begin
                                    r_coef_vld[w_cwaddr] <= 1'b1;
                                end
                            end
                            FUNC_FADE: begin
                                if (!r_fade_run) begin
                                    for (int i = 0; i < 128; i++) begin
                                        if (i[6] != r_active) begin
                                            r_hist_vld[i] <= 1'b0;
                                        end
                                    end
                                    r_fade_run <= 1'b1;
                                    r_pos      <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAC: begin
                    // coef j arrives at r_k = j+1, its product is registered and added at r_k = j+2
                    if (r_k >= 3'd1 && r_k <= 3'd5) begin
                        r_prod <= 64'(w_coef) * 64'(w_opnd);
                        r_psub <= (r_k >= 3'd4);
                    end
                    if (r_k >= 3'd2) begin
                        r_acc <= r_psub ? r_acc - r_prod : r_acc + r_prod;
                    end
                    if (r_k == 3'd6) begin
                        r_state <= S_SEND;
                    end
                    r_k <= r_k + 3'd1;
                end
                S_SEND: begin
                    r_hist_vld[w_haddr] <= 1'b1;
                    r_cur <= w_y;
                    r_k   <= '0;
                    r_acc <= '0;
                    if (r_sec == 3'(NUM_SECTIONS - 1)) begin
                        r_sec <= '0;
                        if (!r_pass) begin
                            r_a <= w_y;
                            r_res <= sat_sample(51'(w_y));
                            if (r_fade_snap) begin
                                r_pass     <= 1'b1;
                                r_bank_run <= ~r_active;
                                r_cur      <= r_x;
                                r_state    <= S_MAC;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_t     <= w_y;
                            r_state <= S_FMUL;
                        end
                    end else begin
                        r_sec   <= r_sec + 3'd1;
                        r_state <= S_MAC;
                    end
                end
                S_FMUL: begin
                    r_mul   <= 50'(w_diff) * 50'($signed({1'b0, w_n}));
                    r_state <= S_FADD;
                end
                S_FADD: begin
                    r_num   <= r_mul + $signed({35'd0, w_len[15:1]});
                    r_state <= S_FMAG;
                end
                S_FMAG: begin
                    // floor division of a negative value via ceil of its magnitude
                    r_neg <= r_num[49];
                    if (r_num[49]) begin
                        r_dividend <= 50'(-r_num) + {34'd0, w_len} - 50'd1;
                    end else begin
                        r_dividend <= r_num;
                    end
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_res   <= sat_sample(w_mix);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid  <= 1'b1;
                        r_och     <= r_ch;
                        r_osample <= r_res;
                        r_ofading <= r_fade_run;
                        r_obank   <= r_was_bank;
                        if (w_frame_end) begin
                            if (w_pos1 >= {1'b0, w_len}) begin
                                r_active   <= ~r_active;
                                r_pos      <= '0;
                                r_fade_run <= 1'b0;
                            end else begin
                                r_pos <= w_pos1[15:0];
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_osample, r_och};
    assign o_m_tuser  = {r_obank, r_ofading};

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside output state");

    a_swap_in_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != $past(r_active)) |-> ($past(r_fade_run) && $past(r_state) == S_OUT))
        else $error("bank swapped without a running fade");

endmodule
`default_nettype wire
